// ===== hw/rtl/ffc_pkg.sv =====
// shared types, format codes and conversion functions for the format converter
// no dependencies
`default_nettype none
package ffc_pkg;

  typedef enum logic [2:0] {
    FMT_F32  = 3'd0,
    FMT_F16  = 3'd1,
    FMT_BF16 = 3'd2,
    FMT_INT8 = 3'd3,
    FMT_INT4 = 3'd4
  } fmt_t;

  localparam logic [0:0] REG_SRC = 1'd0;
  localparam logic [0:0] REG_DST = 1'd1;

  localparam logic [15:0] F16_QNAN = 16'h7E00;
  localparam logic [15:0] F16_INF  = 16'h7C00;

  typedef struct packed {
    logic [31:0] value;
    logic        status;
    logic        last;
  } result_t;

  function automatic logic [15:0] to_bf16(input logic [31:0] bits);
    logic [31:0] sum;
    sum = bits + 32'h0000_7fff + {31'd0, bits[16]};
    return sum[31:16];
  endfunction

  function automatic logic [15:0] to_f16(input logic [31:0] bits);
    logic [15:0] sgn;
    logic [7:0]  ex;
    logic [8:0]  nexp;
    sgn  = {bits[31], 15'd0};
    ex   = bits[30:23];
    nexp = {1'b0, ex} - 9'd112;
    if (ex == 8'hff)
      return (bits[22:0] != 23'd0) ? F16_QNAN : (sgn | F16_INF);
    else if (ex <= 8'd112)
      return sgn;
    else if (ex >= 8'd143)
      return sgn | F16_INF;
    else
      return sgn | {1'b0, nexp[4:0], bits[22:13]};
  endfunction

  function automatic logic [31:0] from_f16(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [9:0] nm;
    logic [3:0] lz;
    logic [7:0] e32;
    ex  = h[14:10];
    man = h[9:0];
    lz  = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (man[i] && lz == 4'd0) lz = 4'(10 - i);
    end
    nm  = man << lz;
    e32 = 8'd113 - {4'd0, lz};
    if (ex == 5'd0) begin
      if (man == 10'd0) return {h[15], 31'd0};
      return {h[15], e32, nm, 13'd0};
    end else if (ex == 5'd31) begin
      return {h[15], 8'hff, man, 13'd0};
    end
    return {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ffc_core.sv =====
// combinational conversion of one element for the current format pair
// depends on ffc_pkg
`default_nettype none
module ffc_core (
  input  wire logic [2:0]      source_format,
  input  wire logic [2:0]      dest_format,
  input  wire logic [31:0]     in_value,
  input  wire logic            in_last,
  output ffc_pkg::result_t     result
);
  import ffc_pkg::*;

  logic [15:0] h;
  assign h = in_value[15:0];

  always_comb begin
    result.value  = 32'd0;
    result.status = 1'b0;
    result.last   = in_last;
    if (source_format > FMT_INT4 || dest_format > FMT_INT4) begin
      result.status = 1'b1;
    end else if (source_format == dest_format) begin
      case (source_format)
        FMT_F32:            result.value = in_value;
        FMT_F16, FMT_BF16:  result.value = {16'd0, h};
        default:            result.value = {24'd0, in_value[7:0]};
      endcase
    end else if (source_format == FMT_F32 && dest_format == FMT_F16) begin
      result.value = {16'd0, to_f16(in_value)};
    end else if (source_format == FMT_F16 && dest_format == FMT_F32) begin
      result.value = from_f16(h);
    end else if (source_format == FMT_F32 && dest_format == FMT_BF16) begin
      result.value = {16'd0, to_bf16(in_value)};
    end else if (source_format == FMT_BF16 && dest_format == FMT_F32) begin
      result.value = {h, 16'd0};
    end else if (source_format == FMT_BF16 && dest_format == FMT_F16) begin
      result.value = {16'd0, to_f16({h, 16'd0})};
    end else if (source_format == FMT_F16 && dest_format == FMT_BF16) begin
      result.value = {16'd0, to_bf16(from_f16(h))};
    end else begin
      result.status = 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/float_format_converter.sv =====
// an accepted request is registered into the result register, or into the skid register first while the output stalls
// throughput: one element per cycle while the skid stage is empty, conversion is a single combinational pass
// a skid stage keeps s_tready high while one result waits on m_tready
// reset clears the formats to float32 and empties both stages
// depends on ffc_pkg and ffc_core
`default_nettype none
module float_format_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // in_value
  input  wire logic        s_tlast,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // out_value
  output      logic        m_tuser,   // out_status
  output      logic        m_tlast
);
  import ffc_pkg::*;

  logic [2:0] source_format;
  logic [2:0] dest_format;
  result_t    conv;
  result_t    out_reg;
  result_t    skid;
  logic       out_valid;
  logic       skid_valid;
  logic       in_req;
  logic       out_take;

  ffc_core u_core (
    .source_format(source_format),
    .dest_format  (dest_format),
    .in_value     (s_tdata),
    .in_last      (s_tlast),
    .result       (conv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_F32;
      dest_format   <= FMT_F32;
    end else if (cfg_we) begin
      if (cfg_index == REG_SRC) source_format <= cfg_data;
      else                      dest_format   <= cfg_data;
    end
  end

  assign s_tready = !skid_valid;
  assign in_req   = s_tvalid && s_tready;
  assign out_take = m_tready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid  <= skid_valid || in_req;
        skid_valid <= 1'b0;
      end else if (in_req) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) out_reg <= skid_valid ? skid : conv;
    if (!out_take && in_req) skid <= conv;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg.value;
  assign m_tuser  = out_reg.status;
  assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid full with empty output");
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !s_tready) else $error("accept while skid full");
  a_req_lands: assert property (@(posedge clk) disable iff (rst)
    in_req |=> out_valid) else $error("accepted request lost");
`endif
endmodule
`default_nettype wire
